// ===== src/smpm_pkg.sv =====
// ----------------------------------------------------------------------------
// smpm_pkg
// Types and constants shared by the shift-and pattern matcher.
// ----------------------------------------------------------------------------
package smpm_pkg;

   localparam int MAX_PATTERN         = 64;
   localparam int POSITION_BITS       = 32;
   localparam int VEC_INDEX_BITS      = $clog2(MAX_PATTERN);
   localparam int LENGTH_BITS         = 7;
   localparam int BYTE_BITS           = 8;
   localparam int INDEX_FIELD_BITS    = 6;
   localparam int MATCH_POSITION_BITS = 32;
   localparam int CSR_INDEX_BITS      = 1;
   localparam int CSR_DATA_BITS       = 7;

   typedef enum logic [1:0] {
      CMD_PATTERN  = 2'd0,
      CMD_TEXT     = 2'd1,
      CMD_NEW_TEXT = 2'd2
   } command_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH = 1'b0,
      CSR_FIRST_ONLY     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                  command;
      logic [BYTE_BITS-1:0]        byte_value;
      logic [INDEX_FIELD_BITS-1:0] pattern_index;
   } req_type;

   typedef struct packed {
      logic [MATCH_POSITION_BITS-1:0] match_position;
      logic                           position_overflow;
   } rsp_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic                 shift;
      logic                 clear;
      logic                 write;
      logic [BYTE_BITS-1:0] data;
   } cell_ctrl_type;

endpackage

// ===== src/smpm_cell.sv =====
// ----------------------------------------------------------------------------
// smpm_cell
// One pattern position: holds its pattern byte and its match vector bit.
// ----------------------------------------------------------------------------
module smpm_cell
   import smpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          write_sel,
   input  logic          enable,
   input  logic          prev_bit,
   output logic          match_bit,
   output logic          next_bit
);

   logic [BYTE_BITS-1:0] pattern_ff;
   logic                 match_ff;
   logic                 match_in;

   assign next_bit  = prev_bit & enable & (pattern_ff == ctrl.data);
   assign match_bit = match_ff;

   always_comb begin
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.shift) begin
         match_in = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write && write_sel) begin
         pattern_ff <= ctrl.data;
      end
   end

endmodule

// ===== src/smpm_rsp_buffer.sv =====
// ----------------------------------------------------------------------------
// smpm_rsp_buffer
// Output register with a skid stage for result transactions.
// ----------------------------------------------------------------------------
module smpm_rsp_buffer
   import smpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || !rsp_stall) begin
         // main slot frees up: refill from skid first, else from new push
         main_valid_in = skid_valid_ff | push;
         main_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds data while main slot is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while buffer is full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (main_valid_ff && main_ff == $past(skid_ff)))
      else $error("skid data not moved into main slot");
`endif

endmodule

// ===== src/shift_and_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// shift_and_pattern_matcher
// Shift-and exact string matcher built as a chain of per-position cells.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      req_type (command, byte, index)
//   rsp_     out        valid / stall      rsp_type (position, overflow)
//   csr_     in         valid / ready      index, data
//
// Every transaction is processed in the cycle it is accepted: one item per
// cycle while req_stall is low, the shift-and update of all cells and the
// match pick in one step. A result is registered before it reaches rsp_.
// Reset clears the match vector, position and halt; pattern bytes stay
// undefined until written. req_stall rises only when both the output
// register and the skid stage hold results; csr_ready is always high.
// ----------------------------------------------------------------------------
module shift_and_pattern_matcher
   import smpm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [LENGTH_BITS-1:0]   pattern_length_ff, pattern_length_in;
   logic                     first_only_ff, first_only_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     saturated_ff, saturated_in;
   logic                     halted_ff, halted_in;

   logic                     accept;
   logic                     is_text;
   logic                     is_clear;
   logic                     hit;
   logic                     buffer_full;
   logic [LENGTH_BITS-1:0]   eff_len;
   logic [LENGTH_BITS-1:0]   len_m1;
   logic [POSITION_BITS-1:0] pos_diff;
   cell_ctrl_type            ctrl;
   rsp_type                  push_data;

   logic [MAX_PATTERN-1:0]   match_vec;
   logic [MAX_PATTERN-1:0]   next_vec;
   logic [MAX_PATTERN-1:0]   cell_prev;
   logic [MAX_PATTERN-1:0]   cell_enable;
   logic [MAX_PATTERN-1:0]   cell_write_sel;

   assign csr_ready = 1'b1;
   assign req_stall = buffer_full;
   assign accept    = req_valid & ~req_stall;
   assign is_text   = accept && (req_data.command == CMD_TEXT) && !halted_ff;
   assign is_clear  = accept && (req_data.command == CMD_NEW_TEXT);

   assign ctrl.shift = is_text;
   assign ctrl.clear = is_clear;
   assign ctrl.write = accept && (req_data.command == CMD_PATTERN);
   assign ctrl.data  = req_data.byte_value;

   assign eff_len = (pattern_length_ff > LENGTH_BITS'(MAX_PATTERN)) ?
                    LENGTH_BITS'(MAX_PATTERN) : pattern_length_ff;
   assign len_m1  = eff_len - LENGTH_BITS'(1);

   assign cell_prev[0] = 1'b1;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j > 0) begin : g_link
         assign cell_prev[j] = match_vec[j-1];
      end
      assign cell_enable[j]    = (LENGTH_BITS'(j) < eff_len);
      assign cell_write_sel[j] = (req_data.pattern_index == INDEX_FIELD_BITS'(j));

      smpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .write_sel (cell_write_sel[j]),
         .enable    (cell_enable[j]),
         .prev_bit  (cell_prev[j]),
         .match_bit (match_vec[j]),
         .next_bit  (next_vec[j])
      );
   end

   assign hit = is_text && (eff_len != '0) && next_vec[len_m1[VEC_INDEX_BITS-1:0]];

   // start offset of the occurrence, wrapping on the counter width
   assign pos_diff = pos_ff - POSITION_BITS'(len_m1);
   assign push_data.match_position    = MATCH_POSITION_BITS'(pos_diff);
   assign push_data.position_overflow = saturated_ff | (pos_ff == POS_MAX);

   always_comb begin
      pos_in       = pos_ff;
      saturated_in = saturated_ff;
      halted_in    = halted_ff;
      if (is_clear) begin
         pos_in       = '0;
         saturated_in = 1'b0;
         halted_in    = 1'b0;
      end else if (is_text) begin
         if (pos_ff == POS_MAX) begin
            saturated_in = 1'b1;
         end else begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
         if (hit && first_only_ff) begin
            halted_in = 1'b1;
         end
      end
   end

   always_comb begin
      pattern_length_in = pattern_length_ff;
      first_only_in     = first_only_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_in = csr_data[LENGTH_BITS-1:0];
            CSR_FIRST_ONLY:     first_only_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         first_only_ff     <= 1'b0;
         pos_ff            <= '0;
         saturated_ff      <= 1'b0;
         halted_ff         <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         first_only_ff     <= first_only_in;
         pos_ff            <= pos_in;
         saturated_ff      <= saturated_in;
         halted_ff         <= halted_in;
      end
   end

   smpm_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (hit),
      .push_data (push_data),
      .full      (buffer_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_zero_length_silent: assert property (@(posedge clock) disable iff (reset)
      (eff_len == '0) |-> !hit)
      else $error("match reported with zero pattern length");

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> ((!hit && (pos_in == pos_ff)) || is_clear))
      else $error("text transaction processed while halted");

   a_new_text_clears: assert property (@(posedge clock) disable iff (reset)
      is_clear |=> (pos_ff == '0 && match_vec == '0 && !halted_ff && !saturated_ff))
      else $error("new text did not clear match state");

   a_vector_within_length: assert property (@(posedge clock) disable iff (reset)
      $past(is_text) |-> ((match_vec & ~$past(cell_enable)) == '0))
      else $error("match vector bit set beyond pattern length");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shift-and pattern matcher. A bit-level model of
// the match vector, text offset and halt flag predicts every match position;
// a checker compares each rsp_ transaction against the oldest prediction.
// Directed cases come first, then a long receiver hold-off that backs up
// req_, then random text phases across many length and first-only settings.
// ----------------------------------------------------------------------------
module tb_top;
   import smpm_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         HOLDOFF_CYCLES = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         MAX_PRINTED    = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // matcher image kept by the bench
   logic [BYTE_BITS-1:0]     pattern_copy [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]   match_bits = '0;
   logic [POSITION_BITS-1:0] text_offset = '0;
   logic                     offset_saturated = 1'b0;
   logic                     matcher_halted = 1'b0;
   logic [LENGTH_BITS-1:0]   cfg_length = '0;
   logic                     cfg_first_only = 1'b0;
   rsp_type                  expected_matches [$];

   int error_count   = 0;
   int quiet_cycles  = 0;
   bit sender_pacing   = 1'b1;
   bit receiver_pacing = 1'b1;
   bit holdoff_request = 1'b0;

   shift_and_pattern_matcher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // one accepted req_ transaction applied to the bench's matcher image
   function automatic void shift_and_update(input req_type item);
      logic [MAX_PATTERN-1:0]   mask;
      logic [POSITION_BITS-1:0] pos;
      rsp_type                  hit;
      int                       eff;
      case (item.command)
         CMD_PATTERN: begin
            pattern_copy[item.pattern_index] = item.byte_value;
         end
         CMD_NEW_TEXT: begin
            match_bits       = '0;
            text_offset      = '0;
            offset_saturated = 1'b0;
            matcher_halted   = 1'b0;
         end
         CMD_TEXT: begin
            if (!matcher_halted) begin
               pos = text_offset;
               // saturate: the last offset is reused for every later byte
               if (pos == {POSITION_BITS{1'b1}}) offset_saturated = 1'b1;
               else text_offset = pos + 1'b1;
               eff  = (cfg_length > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_length);
               mask = '0;
               for (int j = 0; j < MAX_PATTERN; j++) begin
                  if (j < eff && pattern_copy[j] == item.byte_value) mask[j] = 1'b1;
               end
               match_bits = {match_bits[MAX_PATTERN-2:0], 1'b1} & mask;
               if (eff != 0 && match_bits[eff-1]) begin
                  hit.match_position    = pos - POSITION_BITS'(eff - 1);
                  hit.position_overflow = offset_saturated;
                  expected_matches.push_back(hit);
                  if (cfg_first_only) matcher_halted = 1'b1;
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic check_match(input rsp_type got);
      rsp_type want;
      if (expected_matches.size() == 0) begin
         report_mismatch($sformatf("unexpected match, position %0d", got.match_position));
         return;
      end
      want = expected_matches.pop_front();
      if (got.match_position !== want.match_position)
         report_mismatch($sformatf("match_position %0d, expected %0d",
                                   got.match_position, want.match_position));
      if (got.position_overflow !== want.position_overflow)
         report_mismatch($sformatf("position_overflow %0b, expected %0b",
                                   got.position_overflow, want.position_overflow));
   endtask

   // check results before predicting, both on values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_match(rsp_data);
         if (req_valid && !req_stall) shift_and_update(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, mostly short, a few long, plus the hold-off
   initial begin : rsp_pacer
      int hold_left;
      int burst_left;
      int r;
      hold_left  = 0;
      burst_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            hold_left       = HOLDOFF_CYCLES;
            holdoff_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!receiver_pacing) begin
            rsp_stall <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 3) burst_left = $urandom_range(15, 60);
               else if (r < 30) burst_left = $urandom_range(1, 3);
            end
            if (burst_left > 0) begin
               burst_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   function automatic int sender_gap();
      int r;
      if (!sender_pacing) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input logic [7:0] value,
                                        input logic [INDEX_FIELD_BITS-1:0] index);
      req_type item;
      item.command       = cmd;
      item.byte_value    = value;
      item.pattern_index = index;
      return item;
   endfunction

   // valid stays high across back-to-back transactions; drop it only for a gap
   task automatic send_req(input req_type item);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_text(input logic [7:0] value);
      send_req(make_req(CMD_TEXT, value, INDEX_FIELD_BITS'($urandom_range(0, 63))));
   endtask

   // hold until every predicted match has come out and the block is quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_PATTERN_LENGTH) cfg_length = value;
      else cfg_first_only = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      write_csr(CSR_PATTERN_LENGTH, 7'd0);
      write_csr(CSR_FIRST_ONLY, 7'd0);
      send_req(make_req(CMD_PATTERN, 8'h00, 6'd0));
      send_req(make_req(CMD_PATTERN, 8'hFF, 6'd1));
      send_req(make_req(CMD_PATTERN, 8'hFF, 6'd63));
      // zero length never matches
      send_text(8'h00);
      write_csr(CSR_PATTERN_LENGTH, 7'd2);
      send_text(8'h00);
      send_text(8'hFF);
      send_text(8'h00);
      send_text(8'h00);
      send_text(8'hFF);
      send_req(make_req(CMD_UNUSED, 8'hFF, 6'd63));
      send_text(8'hFF);
      send_req(make_req(CMD_NEW_TEXT, 8'hFF, 6'd63));
      // first-only: the second occurrence must be dropped
      write_csr(CSR_FIRST_ONLY, 7'd1);
      send_text(8'h00);
      send_text(8'hFF);
      send_text(8'h00);
      send_text(8'hFF);
      send_req(make_req(CMD_NEW_TEXT, 8'h00, 6'd0));
      send_text(8'h00);
      send_text(8'hFF);
      // shorten the pattern mid-text with vector bits still set
      write_csr(CSR_FIRST_ONLY, 7'd0);
      write_csr(CSR_PATTERN_LENGTH, 7'd1);
      send_text(8'hFF);
      send_text(8'h00);
   endtask

   task automatic run_text_phase(input int len_cfg, input bit first, input int count);
      logic [7:0] letter [2];
      int eff;
      int sent;
      int r;
      int k;
      write_csr(CSR_PATTERN_LENGTH, CSR_DATA_BITS'(len_cfg));
      write_csr(CSR_FIRST_ONLY, CSR_DATA_BITS'(first));
      eff       = (len_cfg > MAX_PATTERN) ? MAX_PATTERN : len_cfg;
      letter[0] = 8'($urandom_range(0, 255));
      letter[1] = letter[0] ^ (8'h01 << $urandom_range(0, 7));
      for (int i = 0; i < eff; i++)
         send_req(make_req(CMD_PATTERN, letter[$urandom_range(0, 1)], INDEX_FIELD_BITS'(i)));
      sent = eff;
      // sometimes keep the old text running across the setting change
      if ($urandom_range(0, 4) != 0)
         send_req(make_req(CMD_NEW_TEXT, 8'($urandom_range(0, 255)),
                           INDEX_FIELD_BITS'($urandom_range(0, 63))));
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 55 && eff > 0) begin
            // whole occurrence most of the time, a broken prefix otherwise
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : eff;
            for (int i = 0; i < k; i++) send_text(pattern_copy[i]);
            sent += k;
         end else if (r < 85) begin
            send_text(letter[$urandom_range(0, 1)]);
            sent++;
         end else if (r < 91) begin
            send_text(8'($urandom_range(0, 255)));
            sent++;
         end else if (r < 95) begin
            send_req(make_req(CMD_PATTERN,
                              ($urandom_range(0, 1) != 0) ? letter[$urandom_range(0, 1)]
                                                          : 8'($urandom_range(0, 255)),
                              INDEX_FIELD_BITS'($urandom_range(0, 63))));
            sent++;
         end else if (r < 98) begin
            send_req(make_req(CMD_NEW_TEXT, 8'($urandom_range(0, 255)),
                              INDEX_FIELD_BITS'($urandom_range(0, 63))));
            sent++;
         end else begin
            send_req(make_req(CMD_UNUSED, 8'($urandom_range(0, 255)),
                              INDEX_FIELD_BITS'($urandom_range(0, 63))));
         end
      end
   endtask

   task automatic test_random_text();
      int len;
      // fill the whole store once so no compare ever reads an unwritten entry
      for (int i = 0; i < MAX_PATTERN; i++)
         send_req(make_req(CMD_PATTERN, 8'($urandom_range(0, 255)), INDEX_FIELD_BITS'(i)));
      for (int p = 0; p < 12; p++) begin
         case (p)
            2:       len = MAX_PATTERN;
            4:       len = 0;
            6:       len = 127;
            9:       len = $urandom_range(65, 126);
            default: len = $urandom_range(1, 6);
         endcase
         sender_pacing   = (p % 4 != 3);
         receiver_pacing = (p % 5 != 4);
         run_text_phase(len, 1'($urandom_range(0, 1)), (len > 8) ? 100 : 50);
      end
      sender_pacing   = 1'b1;
      receiver_pacing = 1'b1;
   endtask

   // every text byte matches while the receiver holds off: req_ must stall
   task automatic test_output_backpressure();
      logic [7:0] value;
      value = 8'($urandom_range(0, 255));
      write_csr(CSR_PATTERN_LENGTH, 7'd1);
      write_csr(CSR_FIRST_ONLY, 7'd0);
      send_req(make_req(CMD_PATTERN, value, 6'd0));
      send_req(make_req(CMD_NEW_TEXT, value, 6'd0));
      sender_pacing   = 1'b0;
      receiver_pacing = 1'b0;
      holdoff_request = 1'b1;
      repeat (40) send_text(value);
      sender_pacing   = 1'b1;
      receiver_pacing = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_output_backpressure();
      test_random_text();
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_matches.size() != 0)
         report_mismatch($sformatf("%0d matches never arrived", expected_matches.size()));
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
